### hw/rtl/lsbs_pkg.sv
package lsbs_pkg;

  localparam int BAR_W        = 5;
  localparam int MAG_W        = 24;
  localparam int HGT_W        = 10;
  localparam int FRAC_W       = 16;
  localparam int MANT_W       = 31;
  localparam int MUL_W        = 32;
  localparam int HQ_W         = 31;
  localparam int SQR_ROUNDS   = 16;
  localparam int CNT_W        = 4;
  localparam int PC_W         = 4;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int DIV3_SHIFT   = 33;
  localparam int NUM_BARS_DEF = 22;
  localparam int BIN_STEP_DEF = 12;

  localparam logic [HGT_W-1:0] PANEL_RESET = 10'd271;
  localparam logic [23:0]      LOG_OFFSET  = 24'd2686822;
  localparam logic [14:0]      LOG_SCALE   = 15'd32072;
  localparam logic [MUL_W-1:0] DIV3_RECIP  = 32'hAAAAAAAB;

  typedef enum logic [0:0] {
    REG_PANEL = 1'b0
  } reg_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_WEIGHT,
    OP_OFFS,
    OP_NORM,
    OP_MANT,
    OP_SQR,
    OP_LDIFF,
    OP_SCL1,
    OP_SCL2,
    OP_DIFF,
    OP_SUM,
    OP_DIV3,
    OP_WB
  } op_e;

  typedef enum logic [2:0] {
    CD_NEXT,
    CD_JUMP,
    CD_NO_BEAT,
    CD_BAD_BAR,
    CD_CNT_NZ,
    CD_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_LEFT,
    RD_CTR,
    RD_RIGHT
  } rd_e;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_L,
    CAP_C
  } cap_e;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_NORM,
    CNT_SQR
  } cnt_e;

  typedef struct packed {
    op_e              op;
    rd_e              rd;
    cap_e             cap;
    logic [CNT_W-1:0] cnt;
  } seq_ctl_t;

  typedef struct packed {
    logic in_beat;
    logic bad_bar;
    logic out_busy;
  } dp_stat_t;

  function automatic int acc_width(int nb, int bs);
    int wmax;
    wmax = (nb - 1) * bs + 1;
    return MAG_W + $clog2(wmax + 1) + 1;
  endfunction

  function automatic logic [63:0] log2q_const(logic [63:0] a);
    logic [63:0] m;
    logic [63:0] frac;
    int          e;
    frac = '0;
    e    = 0;
    for (int i = 0; i < 63; i++) begin
      if ((a >> (i + 1)) != 64'd0) begin
        e = i + 1;
      end
    end
    if (e >= 30) begin
      m = a >> (e - 30);
    end else begin
      m = a << (30 - e);
    end
    for (int i = 0; i < SQR_ROUNDS; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(e) << FRAC_W) | frac;
  endfunction

  localparam logic [63:0] LOG_K = log2q_const(64'(LOG_OFFSET));

  localparam int NORM_STEPS_DEF = $clog2(acc_width(NUM_BARS_DEF, BIN_STEP_DEF));

endpackage

### hw/rtl/lsbs_if.sv
interface lsbs_in_if;
  logic                       valid;
  logic                       ready;
  logic [lsbs_pkg::BAR_W-1:0] bar_number;
  logic [lsbs_pkg::MAG_W-1:0] magnitude;

  modport source (output valid, output bar_number, output magnitude, input ready);
  modport sink (input valid, input bar_number, input magnitude, output ready);
endinterface

interface lsbs_out_if;
  logic                       valid;
  logic                       ready;
  logic [lsbs_pkg::BAR_W-1:0] bar_id;
  logic [lsbs_pkg::HGT_W-1:0] bar_height;

  modport source (output valid, output bar_id, output bar_height, input ready);
  modport sink (input valid, input bar_id, input bar_height, output ready);
endinterface

### hw/rtl/log_spectrum_bar_smoother.sv
// Turns one spectrum magnitude per bar into a smoothed bar height: the magnitude is
// weighted by its bin number, compressed logarithmically to the panel height, diffused
// with its neighbors and averaged with the stored height, then saturated at panel_height.
// One item is in flight at a time. The log of a bar in range takes sixteen squaring
// rounds through the single shared 32x32 multiplier, and the normalization finds the
// shift amount bit by bit, from the highest bit down. A bar number outside the panel
// gives no result. A finished result waits in the output register while the next beat
// is accepted. Stored heights read as zero after reset; no clearing pass is needed.
// panel_height sits at byte address 0 of the configuration port. The user must write
// it only while the block is idle; the block itself does not enforce this.
module log_spectrum_bar_smoother #(
  parameter int NUM_BARS = lsbs_pkg::NUM_BARS_DEF,
  parameter int BIN_STEP = lsbs_pkg::BIN_STEP_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lsbs_in_if.sink                      in_ch,
  lsbs_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsbs_pkg::CFG_AW-1:0]  paddr,
  input  logic [lsbs_pkg::CFG_DW-1:0]  pwdata,
  output logic [lsbs_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);

  localparam int NORM_STEPS = $clog2(lsbs_pkg::acc_width(NUM_BARS, BIN_STEP));
  localparam int HGT_W      = lsbs_pkg::HGT_W;

  logic [HGT_W-1:0]   panel_r;
  logic [HGT_W-1:0]   panel_nxt;
  logic               reg_hit;
  lsbs_pkg::seq_ctl_t ctl;
  lsbs_pkg::dp_stat_t stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[lsbs_pkg::CFG_AW-1] == lsbs_pkg::REG_PANEL);
  assign prdata  = reg_hit ? lsbs_pkg::CFG_DW'(panel_r) : '0;

  always_comb begin
    panel_nxt = panel_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      panel_nxt = pwdata[HGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_r <= lsbs_pkg::PANEL_RESET;
    end else begin
      panel_r <= panel_nxt;
    end
  end

  lsbs_seq #(
    .NORM_STEPS (NORM_STEPS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  lsbs_dp #(
    .NUM_BARS (NUM_BARS),
    .BIN_STEP (BIN_STEP)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .stat   (stat),
    .panel  (panel_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while an item is still in work");

  a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctl.op == lsbs_pkg::OP_WB))
    else $error("result beat raised outside the write-back step");

  a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((lsbs_pkg::BAR_W + 2)'(out_ch.bar_id) <
                      (lsbs_pkg::BAR_W + 2)'(NUM_BARS)))
    else $error("result beat for a bar outside the panel");
`endif

endmodule

### hw/rtl/lsbs_seq.sv
module lsbs_seq #(
  parameter int NORM_STEPS = lsbs_pkg::NORM_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lsbs_pkg::dp_stat_t stat,
  output lsbs_pkg::seq_ctl_t ctl
);

  localparam int PC_W  = lsbs_pkg::PC_W;
  localparam int CNT_W = lsbs_pkg::CNT_W;

  localparam logic [PC_W-1:0] S_IDLE = 4'd0;
  localparam logic [PC_W-1:0] S_WGT  = 4'd1;
  localparam logic [PC_W-1:0] S_OFFS = 4'd2;
  localparam logic [PC_W-1:0] S_NORM = 4'd3;
  localparam logic [PC_W-1:0] S_MANT = 4'd4;
  localparam logic [PC_W-1:0] S_SQR  = 4'd5;
  localparam logic [PC_W-1:0] S_LDIF = 4'd6;
  localparam logic [PC_W-1:0] S_SCL1 = 4'd7;
  localparam logic [PC_W-1:0] S_SCL2 = 4'd8;
  localparam logic [PC_W-1:0] S_DIFF = 4'd9;
  localparam logic [PC_W-1:0] S_SUM  = 4'd10;
  localparam logic [PC_W-1:0] S_DIV3 = 4'd11;
  localparam logic [PC_W-1:0] S_WB   = 4'd12;

  typedef struct packed {
    lsbs_pkg::op_e    op;
    lsbs_pkg::cond_e  cond;
    logic [PC_W-1:0]  target;
    logic             fin;
    lsbs_pkg::rd_e    rd;
    lsbs_pkg::cap_e   cap;
    lsbs_pkg::cnt_e   cnt;
  } uword_t;

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: lsbs_pkg::OP_NOP, cond: lsbs_pkg::CD_NEXT, target: S_IDLE, fin: 1'b0,
          rd: lsbs_pkg::RD_NONE, cap: lsbs_pkg::CAP_NONE, cnt: lsbs_pkg::CNT_KEEP};
    unique case (pc)
      S_IDLE: begin
        w.op     = lsbs_pkg::OP_IDLE;
        w.cond   = lsbs_pkg::CD_NO_BEAT;
        w.target = S_IDLE;
      end
      S_WGT: begin
        w.op     = lsbs_pkg::OP_WEIGHT;
        w.cond   = lsbs_pkg::CD_BAD_BAR;
        w.target = S_IDLE;
      end
      S_OFFS: begin
        w.op  = lsbs_pkg::OP_OFFS;
        w.cnt = lsbs_pkg::CNT_NORM;
      end
      S_NORM: begin
        w.op     = lsbs_pkg::OP_NORM;
        w.cond   = lsbs_pkg::CD_CNT_NZ;
        w.target = S_NORM;
      end
      S_MANT: begin
        w.op  = lsbs_pkg::OP_MANT;
        w.cnt = lsbs_pkg::CNT_SQR;
      end
      S_SQR: begin
        w.op     = lsbs_pkg::OP_SQR;
        w.cond   = lsbs_pkg::CD_CNT_NZ;
        w.target = S_SQR;
      end
      S_LDIF: begin
        w.op = lsbs_pkg::OP_LDIFF;
        w.rd = lsbs_pkg::RD_LEFT;
      end
      S_SCL1: begin
        w.op  = lsbs_pkg::OP_SCL1;
        w.rd  = lsbs_pkg::RD_CTR;
        w.cap = lsbs_pkg::CAP_L;
      end
      S_SCL2: begin
        w.op  = lsbs_pkg::OP_SCL2;
        w.rd  = lsbs_pkg::RD_RIGHT;
        w.cap = lsbs_pkg::CAP_C;
      end
      S_DIFF: begin
        w.op = lsbs_pkg::OP_DIFF;
      end
      S_SUM: begin
        w.op = lsbs_pkg::OP_SUM;
      end
      S_DIV3: begin
        w.op = lsbs_pkg::OP_DIV3;
      end
      S_WB: begin
        w.op     = lsbs_pkg::OP_WB;
        w.cond   = lsbs_pkg::CD_OUT_BUSY;
        w.target = S_WB;
        w.fin    = 1'b1;
      end
      default: begin
        w.cond   = lsbs_pkg::CD_JUMP;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [PC_W-1:0]  pc_r;
  logic [PC_W-1:0]  pc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  uword_t           uw;
  logic             taken;

  always_comb begin
    uw = ucode(pc_r);
    unique case (uw.cond)
      lsbs_pkg::CD_NEXT:     taken = 1'b0;
      lsbs_pkg::CD_JUMP:     taken = 1'b1;
      lsbs_pkg::CD_NO_BEAT:  taken = !stat.in_beat;
      lsbs_pkg::CD_BAD_BAR:  taken = stat.bad_bar;
      lsbs_pkg::CD_CNT_NZ:   taken = (cnt_r != '0);
      lsbs_pkg::CD_OUT_BUSY: taken = stat.out_busy;
      default:               taken = 1'b0;
    endcase

    if (taken) begin
      pc_nxt = uw.target;
    end else if (uw.fin) begin
      pc_nxt = S_IDLE;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end

    unique case (uw.cnt)
      lsbs_pkg::CNT_NORM: cnt_nxt = CNT_W'(NORM_STEPS - 1);
      lsbs_pkg::CNT_SQR:  cnt_nxt = CNT_W'(lsbs_pkg::SQR_ROUNDS - 1);
      default: begin
        if (uw.cond == lsbs_pkg::CD_CNT_NZ && cnt_r != '0) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          cnt_nxt = cnt_r;
        end
      end
    endcase

    ctl = '{op: uw.op, rd: uw.rd, cap: uw.cap, cnt: cnt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/lsbs_dp.sv
module lsbs_dp #(
  parameter int NUM_BARS = lsbs_pkg::NUM_BARS_DEF,
  parameter int BIN_STEP = lsbs_pkg::BIN_STEP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lsbs_pkg::seq_ctl_t          ctl,
  output lsbs_pkg::dp_stat_t          stat,
  input  logic [lsbs_pkg::HGT_W-1:0]  panel,
  lsbs_in_if.sink                     in_ch,
  lsbs_out_if.source                  out_ch
);

  localparam int BAR_W  = lsbs_pkg::BAR_W;
  localparam int MAG_W  = lsbs_pkg::MAG_W;
  localparam int HGT_W  = lsbs_pkg::HGT_W;
  localparam int FRAC_W = lsbs_pkg::FRAC_W;
  localparam int MANT_W = lsbs_pkg::MANT_W;
  localparam int MUL_W  = lsbs_pkg::MUL_W;
  localparam int HQ_W   = lsbs_pkg::HQ_W;
  localparam int A_W    = lsbs_pkg::acc_width(NUM_BARS, BIN_STEP);
  localparam int EXP_W  = $clog2(A_W);
  localparam int LOG_W  = EXP_W + FRAC_W;
  localparam int WGT_W  = $clog2((NUM_BARS - 1) * BIN_STEP + 2);
  localparam int BIX_W  = $clog2(NUM_BARS);
  localparam int ADR_W  = BAR_W + 2;
  localparam int SUM_W  = MUL_W + 2;
  localparam int Q_W    = 2 * MUL_W - lsbs_pkg::DIV3_SHIFT - FRAC_W;

  logic [BAR_W-1:0]   bar_r;
  logic [MAG_W-1:0]   mag_r;
  logic [A_W-1:0]     norm_r;
  logic [EXP_W-1:0]   exp_r;
  logic [MANT_W-1:0]  m_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [LOG_W-1:0]   l_r;
  logic [MUL_W-1:0]   s_r;
  logic [HQ_W-1:0]    hq_r;
  logic [HGT_W-1:0]   lh_r;
  logic [HGT_W-1:0]   ch_r;
  logic [HGT_W-1:0]   rd_r;
  logic [MUL_W-1:0]   dq_r;
  logic [MUL_W-1:0]   n_r;
  logic [Q_W-1:0]     q_r;
  logic [HGT_W-1:0]   mem [NUM_BARS];
  logic [NUM_BARS-1:0] vld_r;
  logic               out_vld_r;
  logic               out_vld_nxt;
  logic [BAR_W-1:0]   obar_r;
  logic [HGT_W-1:0]   oh_r;

  logic [WGT_W-1:0]     wgt;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   prod;
  logic [EXP_W-1:0]     sh;
  logic [A_W-1:0]       hi_mask;
  logic                 hi_zero;
  logic [A_W+MANT_W-1:0] mant_full;
  logic [MANT_W:0]      sq;
  logic [LOG_W-1:0]     la;
  logic [LOG_W-1:0]     lk;
  logic [ADR_W-1:0]     bar_x;
  logic                 r_edge;
  logic [SUM_W-1:0]     hq_x;
  logic [SUM_W-1:0]     lft;
  logic [SUM_W-1:0]     rgt;
  logic [SUM_W-1:0]     dsum;
  logic [ADR_W-1:0]     rd_a;
  logic                 rd_ok;
  logic [BIX_W-1:0]     rd_i;
  logic [BIX_W-1:0]     wr_i;
  logic [HGT_W-1:0]     h_sat;
  logic                 in_beat;
  logic                 out_busy;
  logic                 wb_fire;

  assign in_ch.ready = (ctl.op == lsbs_pkg::OP_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign bar_x       = ADR_W'(bar_r);
  assign out_busy    = out_vld_r && !out_ch.ready;
  assign wb_fire     = (ctl.op == lsbs_pkg::OP_WB) && !out_busy;
  assign stat        = '{in_beat: in_beat, bad_bar: (bar_x >= ADR_W'(NUM_BARS)),
                         out_busy: out_busy};

  assign out_ch.valid      = out_vld_r;
  assign out_ch.bar_id     = obar_r;
  assign out_ch.bar_height = oh_r;

  always_comb begin
    wgt = WGT_W'(bar_r * BIN_STEP + 1);
    unique case (ctl.op)
      lsbs_pkg::OP_WEIGHT: begin
        mul_a = MUL_W'(mag_r);
        mul_b = MUL_W'(wgt);
      end
      lsbs_pkg::OP_SQR: begin
        mul_a = MUL_W'(m_r);
        mul_b = MUL_W'(m_r);
      end
      lsbs_pkg::OP_SCL1: begin
        mul_a = MUL_W'(panel);
        mul_b = MUL_W'(l_r);
      end
      lsbs_pkg::OP_SCL2: begin
        mul_a = s_r;
        mul_b = MUL_W'(lsbs_pkg::LOG_SCALE);
      end
      lsbs_pkg::OP_DIV3: begin
        mul_a = n_r;
        mul_b = lsbs_pkg::DIV3_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = (2 * MUL_W)'(mul_a) * (2 * MUL_W)'(mul_b);

    sh        = EXP_W'(1) << ctl.cnt;
    hi_mask   = ~({A_W{1'b1}} >> sh);
    hi_zero   = ((norm_r & hi_mask) == '0);
    mant_full = {norm_r, MANT_W'(0)};
    sq        = prod[2*MANT_W-1 -: MANT_W+1];

    la = {exp_r, frac_r};
    lk = LOG_W'(lsbs_pkg::LOG_K);

    r_edge = (bar_x + ADR_W'(1)) >= ADR_W'(NUM_BARS);
    hq_x   = SUM_W'(hq_r);
    lft    = (bar_r == '0) ? hq_x : SUM_W'({lh_r, FRAC_W'(0)});
    rgt    = r_edge ? hq_x : SUM_W'({rd_r, FRAC_W'(0)});
    dsum   = (hq_x << 1) + lft + rgt;

    unique case (ctl.rd)
      lsbs_pkg::RD_LEFT:  rd_a = bar_x - ADR_W'(1);
      lsbs_pkg::RD_RIGHT: rd_a = bar_x + ADR_W'(1);
      default:            rd_a = bar_x;
    endcase
    rd_ok = rd_a < ADR_W'(NUM_BARS);
    rd_i  = rd_a[BIX_W-1:0];
    wr_i  = bar_x[BIX_W-1:0];

    h_sat = (q_r > Q_W'(panel)) ? panel : q_r[HGT_W-1:0];

    out_vld_nxt = out_vld_r;
    if (wb_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      bar_r <= in_ch.bar_number;
      mag_r <= in_ch.magnitude;
    end
    unique case (ctl.op)
      lsbs_pkg::OP_WEIGHT: norm_r <= prod[A_W-1:0];
      lsbs_pkg::OP_OFFS: begin
        norm_r <= norm_r + A_W'(lsbs_pkg::LOG_OFFSET);
        exp_r  <= EXP_W'(A_W - 1);
      end
      lsbs_pkg::OP_NORM: begin
        if (hi_zero) begin
          norm_r <= norm_r << sh;
          exp_r  <= exp_r - sh;
        end
      end
      lsbs_pkg::OP_MANT: begin
        m_r    <= mant_full[A_W+MANT_W-1 -: MANT_W];
        frac_r <= '0;
      end
      lsbs_pkg::OP_SQR: begin
        m_r    <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
        frac_r <= {frac_r[FRAC_W-2:0], sq[MANT_W]};
      end
      lsbs_pkg::OP_LDIFF: l_r <= (la > lk) ? (la - lk) : '0;
      lsbs_pkg::OP_SCL1:  s_r <= prod[MUL_W-1:0];
      lsbs_pkg::OP_SCL2:  hq_r <= prod[FRAC_W +: HQ_W];
      lsbs_pkg::OP_DIFF:  dq_r <= dsum[SUM_W-1:2];
      lsbs_pkg::OP_SUM:   n_r <= MUL_W'({ch_r, (FRAC_W + 1)'(0)}) + dq_r;
      lsbs_pkg::OP_DIV3:  q_r <= prod[lsbs_pkg::DIV3_SHIFT + FRAC_W +: Q_W];
      default: begin
      end
    endcase
    unique case (ctl.cap)
      lsbs_pkg::CAP_L: lh_r <= rd_r;
      lsbs_pkg::CAP_C: ch_r <= rd_r;
      default: begin
      end
    endcase
    rd_r <= (rd_ok && vld_r[rd_i]) ? mem[rd_i] : '0;
    if (wb_fire) begin
      mem[wr_i] <= h_sat;
      obar_r    <= bar_r;
      oh_r      <= h_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (wb_fire) begin
        vld_r[wr_i] <= 1'b1;
      end
    end
  end

endmodule

### verif/log_spectrum_bar_smoother_tb.sv
`timescale 1ns / 100ps

module log_spectrum_bar_smoother_tb;
  import lsbs_pkg::*;

  localparam int NUM_BARS    = NUM_BARS_DEF;
  localparam int IDLE_LIMIT  = 1000;
  localparam int SETTLE      = 40;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct {
    logic [BAR_W-1:0] bar;
    logic [HGT_W-1:0] height;
  } bar_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  lsbs_in_if  in_ch ();
  lsbs_out_if out_ch ();

  log_spectrum_bar_smoother dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [HGT_W-1:0] panel_model = PANEL_RESET;
  logic [HGT_W-1:0] stored_heights [NUM_BARS] = '{default: '0};
  bar_result_t      height_queue [$];
  int               error_count = 0;
  int               idle_cycles = 0;
  int               random_items = 0;
  bit               sender_no_gaps = 0;
  bit               receiver_no_stalls = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] log2_q16(input logic [63:0] a);
    logic [63:0] mant;
    logic [63:0] frac;
    int          msb;
    msb  = 0;
    frac = '0;
    for (int i = 0; i < 64; i++) begin
      if (a[i]) begin
        msb = i;
      end
    end
    if (msb >= 30) begin
      mant = a >> (msb - 30);
    end else begin
      mant = a << (30 - msb);
    end
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(msb) << FRAC_W) | frac;
  endfunction

  function automatic logic [HGT_W-1:0] predict_bar_height(input logic [BAR_W-1:0] bar,
                                                          input logic [MAG_W-1:0] mag);
    logic [63:0] weighted;
    logic [63:0] log_in;
    logic [63:0] log_base;
    logic [63:0] span;
    logic [63:0] log_height;
    logic [63:0] left_q;
    logic [63:0] right_q;
    logic [63:0] diffused;
    logic [63:0] smoothed;
    logic [63:0] height;
    weighted   = 64'(mag) * (64'(bar) * 64'(BIN_STEP_DEF) + 64'd1);
    log_in     = log2_q16(weighted + 64'(LOG_OFFSET));
    log_base   = log2_q16(64'(LOG_OFFSET));
    span       = (log_in > log_base) ? log_in - log_base : 64'd0;
    log_height = (64'(panel_model) * span * 64'(LOG_SCALE)) >> FRAC_W;
    left_q     = (bar == 0) ? log_height : 64'(stored_heights[bar-1]) << FRAC_W;
    right_q    = (bar == NUM_BARS - 1) ? log_height : 64'(stored_heights[bar+1]) << FRAC_W;
    diffused   = (2 * log_height + left_q + right_q) >> 2;
    smoothed   = ((64'(stored_heights[bar]) << (FRAC_W + 1)) + diffused) / 64'd3;
    height     = smoothed >> FRAC_W;
    if (height > 64'(panel_model)) begin
      height = 64'(panel_model);
    end
    stored_heights[bar] = height[HGT_W-1:0];
    return height[HGT_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] draw_magnitude();
    logic [31:0] mask;
    case ($urandom_range(0, 3))
      0: begin
        return MAG_W'($urandom);
      end
      1: begin
        return MAG_W'($urandom_range(0, 255));
      end
      2: begin
        mask = (32'd1 << $urandom_range(1, MAG_W)) - 32'd1;
        return MAG_W'($urandom & mask);
      end
      default: begin
        return {MAG_W{1'b1}} - MAG_W'($urandom_range(0, 1000));
      end
    endcase
  endfunction

  // Results are checked before the beat accepted at the same edge is predicted.
  always @(posedge clk) begin
    bar_result_t exp_res;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (height_queue.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result bar %0d height %0d", $time,
                   out_ch.bar_id, out_ch.bar_height);
        end else begin
          exp_res = height_queue.pop_front();
          if (out_ch.bar_id !== exp_res.bar) begin
            error_count++;
            $display("%0t: bar_id expected %0d actual %0d", $time, exp_res.bar,
                     out_ch.bar_id);
          end
          if (out_ch.bar_height !== exp_res.height) begin
            error_count++;
            $display("%0t: bar_height of bar %0d expected %0d actual %0d", $time,
                     exp_res.bar, exp_res.height, out_ch.bar_height);
          end
        end
      end
      if (in_ch.valid && in_ch.ready && in_ch.bar_number < NUM_BARS) begin
        exp_res.bar    = in_ch.bar_number;
        exp_res.height = predict_bar_height(in_ch.bar_number, in_ch.magnitude);
        height_queue.push_back(exp_res);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("log_spectrum_bar_smoother verification failed");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = receiver_no_stalls ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if ($urandom_range(0, 19) == 0) begin
        receiver_no_stalls = !receiver_no_stalls;
      end
    end
  end

  task automatic send_beat(input logic [BAR_W-1:0] bar, input logic [MAG_W-1:0] mag);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.bar_number <= bar;
    in_ch.magnitude  <= mag;
    do @(posedge clk); while (!in_ch.ready);
    if (bar < NUM_BARS) begin
      random_items++;
    end
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (height_queue.size() != 0) @(posedge clk);
  endtask

  task automatic set_panel_height(input logic [CFG_DW-1:0] wdata);
    go_idle();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * REG_PANEL);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    panel_model = wdata[HGT_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[HGT_W-1:0] !== panel_model) begin
      error_count++;
      $display("%0t: panel_height read expected %0d actual %0d", $time, panel_model,
               prdata[HGT_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_panel_edges();
    send_beat(0, '0);
    send_beat(0, {MAG_W{1'b1}});
    send_beat(NUM_BARS - 1, {MAG_W{1'b1}});
    send_beat(NUM_BARS - 1, '0);
    send_beat(10, {MAG_W{1'b1}});
    send_beat(11, 24'd1);
    send_beat(9, 24'h800000);
    send_beat(NUM_BARS, {MAG_W{1'b1}});
    send_beat(5'd31, '0);
    send_beat(1, 24'h123456);
    go_idle();
  endtask

  task automatic test_panel_extremes();
    set_panel_height(32'hFFFF_FC00 | 32'd1023);
    send_beat(0, {MAG_W{1'b1}});
    send_beat(1, 24'h0F0F0F);
    send_beat(NUM_BARS - 1, 24'h00FF00);
    set_panel_height(32'd0);
    send_beat(0, {MAG_W{1'b1}});
    send_beat(12, 24'h555555);
    set_panel_height(32'd1);
    send_beat(2, {MAG_W{1'b1}});
    send_beat(3, 24'hAAAAAA);
    go_idle();
  endtask

  task automatic test_lowered_panel();
    set_panel_height(32'd1023);
    send_beat(4, {MAG_W{1'b1}});
    send_beat(5, {MAG_W{1'b1}});
    send_beat(6, {MAG_W{1'b1}});
    set_panel_height(32'd7);
    send_beat(5, 24'd300);
    send_beat(4, {MAG_W{1'b1}});
    go_idle();
  endtask

  task automatic send_frame();
    int count;
    sender_no_gaps = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 5) != 0) begin
      for (int b = 0; b < NUM_BARS; b++) begin
        if ($urandom_range(0, 40) == 0) begin
          send_beat(BAR_W'($urandom_range(NUM_BARS, 31)), draw_magnitude());
        end
        send_beat(BAR_W'(b), draw_magnitude());
      end
    end else begin
      count = $urandom_range(1, NUM_BARS);
      repeat (count) send_beat(BAR_W'($urandom_range(0, 31)), draw_magnitude());
    end
  endtask

  task automatic test_random_frames();
    int next_setting;
    random_items = 0;
    next_setting = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= next_setting) begin
        next_setting += 170;
        case ($urandom_range(0, 5))
          0: set_panel_height(32'd1023);
          1: set_panel_height(32'd1);
          2: set_panel_height(32'd0);
          3: set_panel_height(32'(PANEL_RESET));
          default: set_panel_height(32'($urandom_range(2, 1022)));
        endcase
      end
      send_frame();
      if ($urandom_range(0, 9) == 0) begin
        go_idle();
        wait_drained();
      end
    end
    sender_no_gaps = 0;
    go_idle();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.bar_number <= '0;
    in_ch.magnitude  <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_panel_edges();
    test_panel_extremes();
    test_lowered_panel();
    test_random_frames();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("log_spectrum_bar_smoother verification clean");
    end else begin
      $display("log_spectrum_bar_smoother verification failed");
    end
    $finish;
  end

endmodule
